// ===== rtl/lea128_block_cipher_core_defines.svh =====
// Assertion macros used by the checker file of the LEA-128 core.
`ifndef LEA128_BLOCK_CIPHER_CORE_DEFINES_SVH
`define LEA128_BLOCK_CIPHER_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define LEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define LEA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/lea_pkg.sv =====
// Types and constants shared by the LEA-128 core and its round cells.
`timescale 1ns / 1ps
`default_nettype none

package lea_pkg;

    localparam int KEY_WORDS_DEF = 96;
    localparam int WORD_W        = 32;
    localparam int KIDX_W        = 7;
    localparam int RND_W         = KIDX_W - 2;
    localparam int S_TDATA_W     = 168;
    localparam int M_TDATA_W     = 4 * WORD_W;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_NOP  = 2'd3
    } lea_op_t;

    typedef struct packed {
        lea_op_t             op;
        logic [KIDX_W-1:0]   key_index;
        logic [WORD_W-1:0]   key_value;
        logic [WORD_W-1:0]   x0;
        logic [WORD_W-1:0]   x1;
        logic [WORD_W-1:0]   x2;
        logic [WORD_W-1:0]   x3;
    } lea_item_t;

endpackage

`default_nettype wire

// ===== rtl/lea_round_cell.sv =====
// One round cell of the LEA chain: holds its round keys and applies one round.
`timescale 1ns / 1ps
`default_nettype none

module lea_round_cell #(
    parameter int ROUNDS = lea_pkg::KEY_WORDS_DEF / 4,
    parameter int INDEX  = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 advance,
    input  wire                 in_valid,
    input  lea_pkg::lea_item_t  in_item,
    output logic                out_valid,
    output lea_pkg::lea_item_t  out_item
);
    import lea_pkg::*;

    localparam logic [RND_W-1:0] ENC_ROUND = RND_W'(INDEX);
    localparam logic [RND_W-1:0] DEC_ROUND = RND_W'(ROUNDS - 1 - INDEX);

    logic [WORD_W-1:0] enc_key_reg [4];
    logic [WORD_W-1:0] dec_key_reg [4];
    logic              valid_reg;
    lea_item_t         item_reg;
    lea_item_t         item_next;

    logic              is_load;
    logic [RND_W-1:0]  load_round;
    logic [1:0]        load_word;
    logic [WORD_W-1:0] e0, e1, e2;
    logic [WORD_W-1:0] p0, p1, p2, p3;

    assign is_load    = in_valid && (in_item.op == OP_LOAD);
    assign load_round = in_item.key_index[KIDX_W-1:2];
    assign load_word  = in_item.key_index[1:0];

    // A load writes this cell as it passes, so items behind it see the new key.
    always_ff @(posedge aclk) begin
        if (advance && is_load) begin
            if (load_round == ENC_ROUND) begin
                enc_key_reg[load_word] <= in_item.key_value;
            end
            if (load_round == DEC_ROUND) begin
                dec_key_reg[load_word] <= in_item.key_value;
            end
        end
    end

    always_comb begin
        e0 = (in_item.x0 ^ enc_key_reg[0]) + (in_item.x1 ^ enc_key_reg[1]);
        e1 = (in_item.x1 ^ enc_key_reg[2]) + (in_item.x2 ^ enc_key_reg[1]);
        e2 = (in_item.x2 ^ enc_key_reg[3]) + (in_item.x3 ^ enc_key_reg[1]);

        p0 = in_item.x3;
        p1 = ({in_item.x0[8:0], in_item.x0[31:9]} - (p0 ^ dec_key_reg[0]))
             ^ dec_key_reg[1];
        p2 = ({in_item.x1[26:0], in_item.x1[31:27]} - (p1 ^ dec_key_reg[2]))
             ^ dec_key_reg[1];
        p3 = ({in_item.x2[28:0], in_item.x2[31:29]} - (p2 ^ dec_key_reg[3]))
             ^ dec_key_reg[1];

        item_next = in_item;
        case (in_item.op)
            OP_ENC: begin
                item_next.x0 = {e0[22:0], e0[31:23]};
                item_next.x1 = {e1[4:0], e1[31:5]};
                item_next.x2 = {e2[2:0], e2[31:3]};
                item_next.x3 = in_item.x0;
            end
            OP_DEC: begin
                item_next.x0 = p0;
                item_next.x1 = p1;
                item_next.x2 = p2;
                item_next.x3 = p3;
            end
            default: begin
                item_next = in_item;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/lea128_block_cipher_core.sv =====
// Top level of the LEA-128 core: a chain of round cells with stream ports.
//
//  channel | direction | tdata                                   | tuser
//  s_      | in        | key_index, key_value, word_a..word_d    | op
//  m_      | out       | out_a..out_d                            | -
//
// Every transfer passes through KEY_WORDS/4 round cells, each of which registers
// it; a block result is taken from the last cell. One transfer is taken per
// cycle unless m_ stalls; loads travel down the chain and write each cell's
// keys in order with the blocks. Reset clears only the valid flags. A stall at
// m_ freezes the whole chain, the last cell being the output register.
`timescale 1ns / 1ps
`default_nettype none

module lea128_block_cipher_core #(
    parameter int KEY_WORDS = lea_pkg::KEY_WORDS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // key_index[6:0], key_value[38:7], word_a[70:39], word_b[102:71],
    // word_c[134:103], word_d[166:135], zero[167]
    input  wire  [lea_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire  [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // out_a[31:0], out_b[63:32], out_c[95:64], out_d[127:96]
    output logic [lea_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lea_pkg::*;

    localparam int ROUNDS = KEY_WORDS / 4;

    logic      advance;
    logic      chain_valid [ROUNDS+1];
    lea_item_t chain_item  [ROUNDS+1];

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // The unused opcode is dropped at the entry.
    assign chain_valid[0]          = s_tvalid && (lea_op_t'(s_tuser) != OP_NOP);
    assign chain_item[0].op        = lea_op_t'(s_tuser);
    assign chain_item[0].key_index = s_tdata[6:0];
    assign chain_item[0].key_value = s_tdata[38:7];
    assign chain_item[0].x0        = s_tdata[70:39];
    assign chain_item[0].x1        = s_tdata[102:71];
    assign chain_item[0].x2        = s_tdata[134:103];
    assign chain_item[0].x3        = s_tdata[166:135];

    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        lea_round_cell #(
            .ROUNDS (ROUNDS),
            .INDEX  (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    assign m_tvalid = chain_valid[ROUNDS] && (chain_item[ROUNDS].op != OP_LOAD);
    assign m_tdata  = {chain_item[ROUNDS].x3, chain_item[ROUNDS].x2,
                       chain_item[ROUNDS].x1, chain_item[ROUNDS].x0};

endmodule

`default_nettype wire

// ===== rtl/lea_core_checker.sv =====
// Port-level checks of the LEA-128 core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lea128_block_cipher_core_defines.svh"

module lea_core_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire [167:0] s_tdata,
    input wire [1:0]   s_tuser,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [127:0] m_tdata
);

    // The chain moves as one, so the input side is free exactly when the output is.
    `LEA_ASSERT(a_ready_follows_output, s_tready == (!m_tvalid || m_tready), "s_tready mismatch")

    // Nothing is left in the chain once reset has been applied.
    `LEA_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid, "result after reset")

    `LEA_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")

    `LEA_ASSERT(a_data_holds, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed")

endmodule

bind lea128_block_cipher_core lea_core_checker u_lea_core_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
